### design/krt_pkg.sv
// Shared types, widths and codes for the keyed record table.
`default_nettype none

package krt_pkg;

    // Default number of record slots
    localparam int unsigned CAPACITY_DEF = 512;

    // Fixed field widths
    localparam int unsigned OPC_W = 2;
    localparam int unsigned KEY_W = 30;
    localparam int unsigned VAL_W = 64;
    localparam int unsigned STS_W = 3;
    localparam int unsigned CNT_OUT_W = 10;

    typedef enum logic [OPC_W-1:0] {
        OP_INSERT   = 2'd0,
        OP_DELETE   = 2'd1,
        OP_RETRIEVE = 2'd2
    } opcode_t;

    typedef enum logic [STS_W-1:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_ABSENT   = 3'd2,
        ST_FULL     = 3'd3,
        ST_MISMATCH = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_RESULT
    } state_t;

    // One stored record
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } rec_t;

    // Controller to datapath
    typedef struct packed {
        logic    load_item;
        logic    scan_start;
        logic    step;
        logic    shift_start;
        logic    shift_write;
        logic    append;
        logic    drop_count;
        logic    set_status;
        status_t status_code;
        logic    post;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic             hit;
        logic             val_eq;
        logic             scan_end;
        logic             full;
        logic             out_free;
        logic [OPC_W-1:0] op;
    } stat_t;

endpackage

`default_nettype wire

### design/keyed_record_table.sv
// Top level of the keyed record table: controller plus datapath.
//
// Keeps up to CAPACITY key/value records packed at the front of one record
// memory in insertion order. Each word is an insert, delete or retrieve and
// returns one result word with a status and the record count after the
// operation. The block takes one word at a time: req_stall is low only while
// it is idle, and a finished result waits in an output register so the next
// word can be taken while the result is still stalled. The scan stops at the
// first matching key, and a delete compacts the table by moving each record
// behind the deleted slot down one slot. The record memory does one read and
// one write per cycle. There is no clearing pass after reset; slots beyond
// the fill count are never read.
`default_nettype none

module keyed_record_table
#(
    parameter int unsigned CAPACITY = krt_pkg::CAPACITY_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire logic [krt_pkg::OPC_W-1:0]     opcode,
    input  wire logic [krt_pkg::KEY_W-1:0]     record_key,
    input  wire logic [krt_pkg::VAL_W-1:0]     value_word,
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output logic [krt_pkg::STS_W-1:0]          status,
    output logic [krt_pkg::CNT_OUT_W-1:0]      entries_held
);

    krt_pkg::cmd_t  cmd;
    krt_pkg::stat_t st;

    krt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .st        (st),
        .cmd       (cmd)
    );

    krt_datapath
    #(
        .CAPACITY (CAPACITY)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .opcode       (opcode),
        .record_key   (record_key),
        .value_word   (value_word),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .status       (status),
        .entries_held (entries_held),
        .cmd          (cmd),
        .st           (st)
    );

endmodule

`default_nettype wire

### design/krt_ctrl.sv
// Controller state machine for the keyed record table.
`default_nettype none

module krt_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire krt_pkg::stat_t st,
    output krt_pkg::cmd_t      cmd
);

    krt_pkg::state_t state_reg;
    krt_pkg::state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= krt_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            krt_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = krt_pkg::S_SEARCH;
                end
            end
            krt_pkg::S_SEARCH:
            begin
                if (st.hit)
                begin
                    if (st.op == krt_pkg::OP_DELETE)
                    begin
                        state_next = krt_pkg::S_SHIFT;
                    end
                    else
                    begin
                        state_next = krt_pkg::S_RESULT;
                    end
                end
                else if (st.scan_end)
                begin
                    state_next = krt_pkg::S_RESULT;
                end
            end
            krt_pkg::S_SHIFT:
            begin
                if (st.scan_end)
                begin
                    state_next = krt_pkg::S_RESULT;
                end
            end
            krt_pkg::S_RESULT:
            begin
                if (st.out_free)
                begin
                    state_next = krt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = krt_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd = '0;
        cmd.status_code = krt_pkg::ST_ABSENT;
        req_stall = 1'b1;
        case (state_reg)
            krt_pkg::S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load_item  = 1'b1;
                    cmd.scan_start = 1'b1;
                end
            end
            krt_pkg::S_SEARCH:
            begin
                if (st.hit)
                begin
                    case (st.op)
                        krt_pkg::OP_INSERT:
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = krt_pkg::ST_DUP;
                        end
                        krt_pkg::OP_DELETE:
                        begin
                            cmd.shift_start = 1'b1;
                        end
                        krt_pkg::OP_RETRIEVE:
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = st.val_eq ? krt_pkg::ST_OK
                                                        : krt_pkg::ST_MISMATCH;
                        end
                        default:
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = krt_pkg::ST_ABSENT;
                        end
                    endcase
                end
                else if (st.scan_end)
                begin
                    cmd.set_status = 1'b1;
                    if (st.op == krt_pkg::OP_INSERT)
                    begin
                        if (st.full)
                        begin
                            cmd.status_code = krt_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.append      = 1'b1;
                            cmd.status_code = krt_pkg::ST_OK;
                        end
                    end
                    else
                    begin
                        cmd.status_code = krt_pkg::ST_ABSENT;
                    end
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            krt_pkg::S_SHIFT:
            begin
                cmd.shift_write = 1'b1;
                if (st.scan_end)
                begin
                    cmd.drop_count  = 1'b1;
                    cmd.set_status  = 1'b1;
                    cmd.status_code = krt_pkg::ST_OK;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            krt_pkg::S_RESULT:
            begin
                cmd.post = st.out_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/krt_datapath.sv
// Record memory, scan pointers, fill count and result register.
`default_nettype none

module krt_datapath
#(
    parameter int unsigned CAPACITY = krt_pkg::CAPACITY_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [krt_pkg::OPC_W-1:0]     opcode,
    input  wire logic [krt_pkg::KEY_W-1:0]     record_key,
    input  wire logic [krt_pkg::VAL_W-1:0]     value_word,
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output logic [krt_pkg::STS_W-1:0]          status,
    output logic [krt_pkg::CNT_OUT_W-1:0]      entries_held,
    input  wire krt_pkg::cmd_t                 cmd,
    output krt_pkg::stat_t                     st
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    krt_pkg::rec_t mem [CAPACITY];

    // Current word
    logic [krt_pkg::OPC_W-1:0] op_reg;
    logic [krt_pkg::KEY_W-1:0] key_reg;
    logic [krt_pkg::VAL_W-1:0] val_reg;

    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic [CW-1:0]  rd_idx_reg;
    logic [CW-1:0]  rd_idx_next;
    logic           pend_reg;
    logic           pend_next;
    logic [AW-1:0]  pend_idx_reg;
    logic [AW-1:0]  pend_idx_next;
    krt_pkg::rec_t  rd_data_reg;

    logic                         rsp_valid_reg;
    logic                         rsp_valid_next;
    krt_pkg::status_t             sts_reg;
    krt_pkg::status_t             sts_next;
    krt_pkg::status_t             out_sts_reg;
    logic [krt_pkg::CNT_OUT_W-1:0] out_cnt_reg;

    logic                               rd_en;
    logic                               wr_en;
    logic [AW-1:0]                      wr_addr;
    krt_pkg::rec_t                      wr_data;
    logic                               more;
    logic                               out_free;
    logic [CW+krt_pkg::CNT_OUT_W-1:0]   cnt_ext;

    assign more     = (rd_idx_reg < count_reg);
    assign rd_en    = cmd.step && more;
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign cnt_ext  = {{krt_pkg::CNT_OUT_W{1'b0}}, count_reg};

    // Pick the write: append at the end, or move a record down one slot
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = count_reg[AW-1:0];
        wr_data = '{key: key_reg, value: val_reg};
        if (cmd.append)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.shift_write && pend_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = pend_idx_reg - AW'(1);
            wr_data = rd_data_reg;
        end
    end

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx_reg[AW-1:0]];
        end
    end

    // Capture the accepted word
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg  <= opcode;
            key_reg <= record_key;
            val_reg <= value_word;
        end
    end

    // Advance pointers, count and result
    always_comb
    begin
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        sts_next       = sts_reg;
        rsp_valid_next = rsp_valid_reg;

        if (cmd.scan_start)
        begin
            rd_idx_next = '0;
            pend_next   = 1'b0;
        end
        else if (cmd.shift_start)
        begin
            rd_idx_next = CW'(pend_idx_reg) + CW'(1);
            pend_next   = 1'b0;
        end
        else if (cmd.step)
        begin
            pend_next = more;
            if (more)
            begin
                pend_idx_next = rd_idx_reg[AW-1:0];
                rd_idx_next   = rd_idx_reg + CW'(1);
            end
        end

        if (cmd.append)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.drop_count)
        begin
            count_next = count_reg - CW'(1);
        end

        if (cmd.set_status)
        begin
            sts_next = cmd.status_code;
        end

        // Drop the result once taken, raise it when posted
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        if (cmd.post)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        sts_reg      <= sts_next;
        if (cmd.post)
        begin
            out_sts_reg <= sts_reg;
            out_cnt_reg <= cnt_ext[krt_pkg::CNT_OUT_W-1:0];
        end
    end

    // Status to controller
    assign st.hit      = pend_reg && (rd_data_reg.key == key_reg);
    assign st.val_eq   = (rd_data_reg.value == val_reg);
    assign st.scan_end = !pend_reg && !more;
    assign st.full     = (count_reg >= CW'(CAPACITY));
    assign st.out_free = out_free;
    assign st.op       = op_reg;

    assign rsp_valid    = rsp_valid_reg;
    assign status       = out_sts_reg;
    assign entries_held = out_cnt_reg;

endmodule

`default_nettype wire

### design/krt_checker.sv
// Port-level assertions for the keyed record table, bound to the top level.
`default_nettype none

module krt_checker
#(
    parameter int unsigned CAPACITY = krt_pkg::CAPACITY_DEF
)
(
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          req_valid,
    input wire logic                          req_stall,
    input wire logic [krt_pkg::OPC_W-1:0]     opcode,
    input wire logic [krt_pkg::KEY_W-1:0]     record_key,
    input wire logic [krt_pkg::VAL_W-1:0]     value_word,
    input wire logic                          rsp_valid,
    input wire logic                          rsp_stall,
    input wire logic [krt_pkg::STS_W-1:0]     status,
    input wire logic [krt_pkg::CNT_OUT_W-1:0] entries_held
);

    localparam logic [krt_pkg::CNT_OUT_W-1:0] FULL_CNT =
        krt_pkg::CNT_OUT_W'(CAPACITY);
    localparam logic SMALL = (CAPACITY < 1024);

    // A stalled result word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(status)
                                   && $stable(entries_held))
        else $error("stalled result word changed");

    // The block goes busy right after taking a word
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("word taken while block still idle");

    // A new result only comes out of a busy cycle
    a_post_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("result posted from idle");

    // Full status only with every slot in use
    a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == krt_pkg::ST_FULL) |-> entries_held == FULL_CNT)
        else $error("table full reported with free slots");

    // An empty table cannot match a key
    a_empty_hit: assert property (@(posedge clk) disable iff (!rst_n)
        SMALL && rsp_valid && (entries_held == '0)
            |-> (status != krt_pkg::ST_DUP) && (status != krt_pkg::ST_MISMATCH))
        else $error("key matched in an empty table");

endmodule

bind keyed_record_table krt_checker #(.CAPACITY(CAPACITY)) u_krt_checker (.*);

`default_nettype wire
